@@ rtl/core/cpm_pkg.sv @@
package cpm_pkg;

  localparam int FRAMES     = 16;
  localparam int ENTRIES    = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int SPACES     = 4;

  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int OFF_W     = $clog2(PAGE_BYTES);
  localparam int PN_W      = 32 - OFF_W;
  localparam int SPACE_W   = $clog2(SPACES);
  localparam int EIDX_W    = $clog2(ENTRIES);
  localparam int EADDR_W   = SPACE_W + EIDX_W;
  localparam int COUNT_W   = $clog2(ENTRIES + 1);
  localparam int BADDR_W   = FRAME_W + OFF_W;
  localparam int SWEEP_W   = OFF_W + 1;
  localparam int REFS_W    = 16;

  localparam logic [31:0] MAP_LO_RST = 32'h4000_0000;
  localparam logic [31:0] MAP_HI_RST = 32'h4100_0000;

  // entry flag bit positions
  localparam int FLAG_PRESENT = 0;
  localparam int FLAG_WRITE   = 1;
  localparam int FLAG_COW     = 2;

  localparam logic [0:0] REG_MAP_LO = 1'b0;
  localparam logic [0:0] REG_MAP_HI = 1'b1;

  typedef enum logic [2:0] {
    CMD_POOL_RESET = 3'd0,
    CMD_ALLOC      = 3'd1,
    CMD_MAP        = 3'd2,
    CMD_CLONE      = 3'd3,
    CMD_DESTROY    = 3'd4,
    CMD_WRITE      = 3'd5,
    CMD_READ       = 3'd6
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_BYTE_OUT,
    ST_COPY,
    ST_FIX_ENTRY,
    ST_WR_PREP,
    ST_ZFILL,
    ST_DES_RD,
    ST_DES_CHK,
    ST_CLN_RD,
    ST_CLN_CHK,
    ST_CLN_MAP
  } state_t;

  typedef struct packed {
    logic [PN_W-1:0]    page;
    logic [FRAME_W-1:0] frame;
    logic [2:0]         flags;
  } entry_t;

endpackage

@@ rtl/core/cpm_ram.sv @@
module cpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/cow_page_mapper_unit.sv @@
// Copy-on-write page mapper: pool reset, alloc, map, bad commands and trivial clone, destroy
// or access of an empty list answer in the cycle after the transaction is taken.
// Read/write: read and check per scanned mapping entry, then a byte fetch (read), an entry
// rewrite (upgrade in place), a page copy to a fresh frame (shared fault) and a zero fill
// (first write to a frame). Destroy: read and check per entry; clone: same per parent entry,
// plus child teardown when a mapping is refused. One command at a time; receiver cannot stall.
// Reset: counts, used bits and refs cleared, all frames flagged zero; no memory sweep.
module cow_page_mapper_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  cmd,
  input  logic [cpm_pkg::SPACE_W-1:0] space,
  input  logic [cpm_pkg::SPACE_W-1:0] source_space,
  input  logic [31:0]                 vaddr,
  input  logic [cpm_pkg::FRAME_W-1:0] frame,
  input  logic                        map_writable,
  input  logic                        map_cow,
  input  logic [7:0]                  write_data,
  input  logic                        cfg_write,
  input  logic [0:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  output logic                        done,
  output logic                        ok,
  output logic [cpm_pkg::FRAME_W-1:0] alloc_frame,
  output logic [7:0]                  read_data
);

  import cpm_pkg::*;

  // control state
  state_t state, state_next;
  logic [31:0] map_lo, map_hi;
  logic [FRAMES-1:0] used, used_next;
  // a set zero bit means the frame reads as all zero whatever the byte store holds
  logic [FRAMES-1:0] zero, zero_next;
  logic [REFS_W-1:0] refs [FRAMES];
  logic [REFS_W-1:0] refs_next [FRAMES];
  logic [COUNT_W-1:0] ecount [SPACES];
  logic [COUNT_W-1:0] ecount_next [SPACES];
  logic done_next, ok_next;
  logic [FRAME_W-1:0] alloc_frame_next;
  logic [7:0] read_data_next;

  // captured transaction and walk state
  cmd_t cmd_q, cmd_q_next;
  logic [SPACE_W-1:0] sp_q, sp_q_next, ps_q, ps_q_next;
  logic [31:0] va_q, va_q_next;
  logic [7:0] wd_q, wd_q_next;
  logic [COUNT_W-1:0] idx, idx_next, idx_inc;
  logic [EADDR_W-1:0] hit_k, hit_k_next;
  entry_t ent_q, ent_q_next;
  logic [FRAME_W-1:0] nf, nf_next;
  logic [SWEEP_W-1:0] cnt, cnt_next;
  logic [SWEEP_W-1:0] cnt_dec;

  // memory ports
  logic ent_we;
  logic [EADDR_W-1:0] ent_waddr, ent_raddr;
  entry_t ent_wdata, ent_rdata;
  logic byte_we;
  logic [BADDR_W-1:0] byte_waddr, byte_raddr;
  logic [7:0] byte_wdata, byte_rdata;

  // helpers
  logic [FRAME_W-1:0] ff_idx;
  logic ff_any;
  logic [FRAME_W-1:0] ref_sel;
  logic [REFS_W-1:0] ref_cur;
  logic [REFS_W-1:0] ref_dec;
  logic [31:0] cln_va;
  logic [2:0] cln_fl;

  cpm_ram #(.WIDTH($bits(entry_t)), .DEPTH(SPACES * ENTRIES)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  cpm_ram #(.WIDTH(8), .DEPTH(FRAMES * PAGE_BYTES)) u_bytes (
    .clk   (clk),
    .we    (byte_we),
    .waddr (byte_waddr),
    .wdata (byte_wdata),
    .raddr (byte_raddr),
    .rdata (byte_rdata)
  );

  assign busy = (state != ST_IDLE);

  // lowest free frame
  always_comb begin
    ff_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        ff_idx = FRAME_W'(i);
      end
    end
  end
  assign ff_any = ~&used;

  // one refcount read a cycle: the old frame during a copy, else the entry just read
  assign ref_sel = (state == ST_COPY) ? ent_q.frame : ent_rdata.frame;
  assign ref_cur = refs[ref_sel];
  assign ref_dec = ref_cur - REFS_W'(1);
  assign idx_inc = idx + COUNT_W'(1);
  assign cnt_dec = cnt - SWEEP_W'(1);
  assign cln_va  = {ent_q.page, {OFF_W{1'b0}}};
  assign cln_fl  = (ent_rdata.flags[FLAG_WRITE])
                   ? ((ent_rdata.flags & ~3'(1 << FLAG_WRITE)) | 3'(1 << FLAG_COW))
                   : ent_rdata.flags;

  always_comb begin
    state_next       = state;
    used_next        = used;
    zero_next        = zero;
    refs_next        = refs;
    ecount_next      = ecount;
    cmd_q_next       = cmd_q;
    sp_q_next        = sp_q;
    ps_q_next        = ps_q;
    va_q_next        = va_q;
    wd_q_next        = wd_q;
    idx_next         = idx;
    hit_k_next       = hit_k;
    ent_q_next       = ent_q;
    nf_next          = nf;
    cnt_next         = cnt;
    done_next        = 1'b0;
    ok_next          = 1'b0;
    alloc_frame_next = '0;
    read_data_next   = '0;
    ent_we           = 1'b0;
    ent_waddr        = '0;
    ent_wdata        = '0;
    ent_raddr        = '0;
    byte_we          = 1'b0;
    byte_waddr       = '0;
    byte_wdata       = '0;
    byte_raddr       = '0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_q_next = cmd_t'(cmd);
          sp_q_next  = space;
          ps_q_next  = source_space;
          va_q_next  = vaddr;
          wd_q_next  = write_data;
          idx_next   = '0;
          unique case (cmd)
            CMD_POOL_RESET: begin
              used_next = '0;
              zero_next = '1;
              for (int i = 0; i < FRAMES; i++) begin
                refs_next[i] = '0;
              end
              done_next = 1'b1;
              ok_next   = 1'b1;
            end
            CMD_ALLOC: begin
              done_next = 1'b1;
              if (ff_any) begin
                used_next[ff_idx] = 1'b1;
                zero_next[ff_idx] = 1'b1;
                refs_next[ff_idx] = REFS_W'(1);
                ok_next           = 1'b1;
                alloc_frame_next  = ff_idx;
              end
            end
            CMD_MAP: begin
              done_next = 1'b1;
              if (used[frame] && ecount[space] < COUNT_W'(ENTRIES) &&
                  vaddr >= map_lo && vaddr < map_hi &&
                  vaddr[OFF_W-1:0] == '0) begin
                ent_we          = 1'b1;
                ent_waddr       = {space, ecount[space][EIDX_W-1:0]};
                ent_wdata.page  = vaddr[31:OFF_W];
                ent_wdata.frame = frame;
                ent_wdata.flags = {map_cow, map_writable, 1'b1};
                ecount_next[space] = ecount[space] + COUNT_W'(1);
                ok_next         = 1'b1;
              end
            end
            CMD_CLONE: begin
              // child list is dropped first; its frames are not released
              ecount_next[space] = '0;
              if (space == source_space || ecount[source_space] == '0) begin
                done_next = 1'b1;
                ok_next   = 1'b1;
              end else begin
                state_next = ST_CLN_RD;
              end
            end
            CMD_DESTROY: begin
              if (ecount[space] == '0) begin
                done_next = 1'b1;
                ok_next   = 1'b1;
              end else begin
                state_next = ST_DES_RD;
              end
            end
            CMD_WRITE, CMD_READ: begin
              if (ecount[space] == '0) begin
                done_next = 1'b1;
              end else begin
                state_next = ST_SCAN_RD;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN_RD: begin
        ent_raddr  = {sp_q, idx[EIDX_W-1:0]};
        state_next = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (ent_rdata.flags[FLAG_PRESENT] && ent_rdata.page == va_q[31:OFF_W]) begin
          ent_q_next = ent_rdata;
          hit_k_next = {sp_q, idx[EIDX_W-1:0]};
          if (cmd_q == CMD_READ) begin
            if (zero[ent_rdata.frame]) begin
              done_next  = 1'b1;
              ok_next    = 1'b1;
              state_next = ST_IDLE;
            end else begin
              byte_raddr = {ent_rdata.frame, va_q[OFF_W-1:0]};
              state_next = ST_BYTE_OUT;
            end
          end else if (ent_rdata.flags[FLAG_WRITE]) begin
            state_next = ST_WR_PREP;
          end else if (!ent_rdata.flags[FLAG_COW] || !used[ent_rdata.frame] ||
                       ref_cur == '0) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else if (ref_cur == REFS_W'(1)) begin
            // sole owner: just make it writable
            ent_q_next.flags = (ent_rdata.flags | 3'(1 << FLAG_WRITE)) & ~3'(1 << FLAG_COW);
            state_next = ST_FIX_ENTRY;
          end else if (!ff_any) begin
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            used_next[ff_idx] = 1'b1;
            refs_next[ff_idx] = REFS_W'(1);
            nf_next           = ff_idx;
            cnt_next          = '0;
            // a zeroed source leaves the new frame zeroed: nothing to copy
            zero_next[ff_idx] = zero[ent_rdata.frame];
            state_next        = ST_COPY;
          end
        end else if (idx_inc == ecount[sp_q]) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = ST_SCAN_RD;
        end
      end

      ST_BYTE_OUT: begin
        done_next      = 1'b1;
        ok_next        = 1'b1;
        read_data_next = byte_rdata;
        state_next     = ST_IDLE;
      end

      ST_COPY: begin
        // read byte n while writing byte n-1 into the new frame
        byte_raddr = {ent_q.frame, cnt[OFF_W-1:0]};
        if (cnt != '0) begin
          byte_we    = !zero[ent_q.frame];
          byte_waddr = {nf, cnt_dec[OFF_W-1:0]};
          byte_wdata = byte_rdata;
        end
        cnt_next = cnt + SWEEP_W'(1);
        if (zero[ent_q.frame] || cnt == SWEEP_W'(PAGE_BYTES)) begin
          // release the old frame (count is at least two here)
          if (used[ent_q.frame] && ref_cur != '0) begin
            refs_next[ent_q.frame] = ref_dec;
            if (ref_dec == '0) begin
              used_next[ent_q.frame] = 1'b0;
              zero_next[ent_q.frame] = 1'b1;
            end
          end
          ent_q_next.frame = nf;
          ent_q_next.flags = (ent_q.flags | 3'(1 << FLAG_WRITE)) & ~3'(1 << FLAG_COW);
          state_next       = ST_FIX_ENTRY;
        end
      end

      ST_FIX_ENTRY: begin
        ent_we     = 1'b1;
        ent_waddr  = hit_k;
        ent_wdata  = ent_q;
        state_next = ST_WR_PREP;
      end

      ST_WR_PREP: begin
        if (zero[ent_q.frame]) begin
          cnt_next   = '0;
          state_next = ST_ZFILL;
        end else begin
          byte_we    = 1'b1;
          byte_waddr = {ent_q.frame, va_q[OFF_W-1:0]};
          byte_wdata = wd_q;
          done_next  = 1'b1;
          ok_next    = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_ZFILL: begin
        byte_we    = 1'b1;
        byte_waddr = {ent_q.frame, cnt[OFF_W-1:0]};
        byte_wdata = '0;
        cnt_next   = cnt + SWEEP_W'(1);
        if (cnt == SWEEP_W'(PAGE_BYTES - 1)) begin
          zero_next[ent_q.frame] = 1'b0;
          state_next = ST_WR_PREP;
        end
      end

      ST_DES_RD: begin
        ent_raddr  = {sp_q, idx[EIDX_W-1:0]};
        state_next = ST_DES_CHK;
      end

      ST_DES_CHK: begin
        if (ent_rdata.flags[FLAG_PRESENT] && used[ent_rdata.frame] && ref_cur != '0) begin
          refs_next[ent_rdata.frame] = ref_dec;
          if (ref_dec == '0) begin
            used_next[ent_rdata.frame] = 1'b0;
            zero_next[ent_rdata.frame] = 1'b1;
          end
        end
        if (idx_inc == ecount[sp_q]) begin
          ecount_next[sp_q] = '0;
          done_next  = 1'b1;
          ok_next    = (cmd_q == CMD_DESTROY);
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = ST_DES_RD;
        end
      end

      ST_CLN_RD: begin
        ent_raddr  = {ps_q, idx[EIDX_W-1:0]};
        state_next = ST_CLN_CHK;
      end

      ST_CLN_CHK: begin
        if (ent_rdata.flags[FLAG_PRESENT]) begin
          // downgrade the parent entry and take a reference for the child
          ent_we          = 1'b1;
          ent_waddr       = {ps_q, idx[EIDX_W-1:0]};
          ent_wdata       = ent_rdata;
          ent_wdata.flags = cln_fl;
          if (used[ent_rdata.frame]) begin
            refs_next[ent_rdata.frame] = ref_cur + REFS_W'(1);
          end
          ent_q_next       = ent_rdata;
          ent_q_next.flags = cln_fl;
          state_next       = ST_CLN_MAP;
        end else if (idx_inc == ecount[ps_q]) begin
          done_next  = 1'b1;
          ok_next    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx_inc;
          state_next = ST_CLN_RD;
        end
      end

      ST_CLN_MAP: begin
        if (used[ent_q.frame] && ecount[sp_q] < COUNT_W'(ENTRIES) &&
            cln_va >= map_lo && cln_va < map_hi) begin
          ent_we          = 1'b1;
          ent_waddr       = {sp_q, ecount[sp_q][EIDX_W-1:0]};
          ent_wdata       = ent_q;
          ent_wdata.flags = ent_q.flags | 3'(1 << FLAG_PRESENT);
          ecount_next[sp_q] = ecount[sp_q] + COUNT_W'(1);
          if (idx_inc == ecount[ps_q]) begin
            done_next  = 1'b1;
            ok_next    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = ST_CLN_RD;
          end
        end else if (ecount[sp_q] == '0) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          // refused: tear the child down, result ok 0
          idx_next   = '0;
          state_next = ST_DES_RD;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      map_lo      <= MAP_LO_RST;
      map_hi      <= MAP_HI_RST;
      used        <= '0;
      zero        <= '1;
      done        <= 1'b0;
      ok          <= 1'b0;
      alloc_frame <= '0;
      read_data   <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        refs[i] <= '0;
      end
      for (int i = 0; i < SPACES; i++) begin
        ecount[i] <= '0;
      end
    end else begin
      state       <= state_next;
      used        <= used_next;
      zero        <= zero_next;
      refs        <= refs_next;
      ecount      <= ecount_next;
      done        <= done_next;
      ok          <= ok_next;
      alloc_frame <= alloc_frame_next;
      read_data   <= read_data_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAP_LO: map_lo <= cfg_data;
          REG_MAP_HI: map_hi <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // transaction payload and walk registers
  always_ff @(posedge clk) begin
    cmd_q <= cmd_q_next;
    sp_q  <= sp_q_next;
    ps_q  <= ps_q_next;
    va_q  <= va_q_next;
    wd_q  <= wd_q_next;
    idx   <= idx_next;
    hit_k <= hit_k_next;
    ent_q <= ent_q_next;
    nf    <= nf_next;
    cnt   <= cnt_next;
  end

endmodule
